// File: design/evcp_pkg.sv
`default_nettype none

package evcp_pkg;

	localparam int unsigned StateW   = 3;
	localparam int unsigned PilotW   = 3;
	localparam int unsigned AmpsW    = 6;
	localparam int unsigned ErrW     = 2;

	localparam logic [AmpsW-1:0] LimitReset = 6'd32;

	typedef enum logic [StateW-1:0] {
		ST_IDLE        = 3'd0,
		ST_CONNECTED   = 3'd1,
		ST_CHARGE_REQ  = 3'd2,
		ST_CHARGING    = 3'd3,
		ST_VENTILATION = 3'd4,
		ST_FAULT       = 3'd5
	} state_t;

	localparam logic [PilotW-1:0] PL_A = 3'd0;
	localparam logic [PilotW-1:0] PL_B = 3'd1;
	localparam logic [PilotW-1:0] PL_C = 3'd2;
	localparam logic [PilotW-1:0] PL_D = 3'd3;

	localparam logic [ErrW-1:0] ERR_NONE          = 2'd0;
	localparam logic [ErrW-1:0] ERR_INVALID_STATE = 2'd1;
	localparam logic [ErrW-1:0] ERR_CONTACTOR     = 2'd2;

	// one input beat
	typedef struct packed {
		logic [PilotW-1:0] pilot_state;
		logic [AmpsW-1:0]  cable_rating_amps;
		logic              cable_valid;
		logic              contactor_feedback_closed;
		logic              error_pending;
	} item_t;

	// one decision: the new state plus the per-tick flags
	typedef struct packed {
		logic [StateW-1:0] state;
		logic [AmpsW-1:0]  pilot_current_amps;
		logic              contactor_on;
		logic [ErrW-1:0]   error_report;
		logic              error_clear;
		logic              state_changed;
	} result_t;

endpackage

`default_nettype wire

// File: design/evcp_step.sv
`default_nettype none

// Next-state decision for one tick of the pilot state machine.
module evcp_step (
	input  wire logic [evcp_pkg::StateW-1:0] cur_state,
	input  wire logic [evcp_pkg::AmpsW-1:0]  cur_current,
	input  wire logic                        cur_contactor,
	input  wire logic [evcp_pkg::AmpsW-1:0]  charger_limit_amps,
	input  wire evcp_pkg::item_t             item,
	output evcp_pkg::result_t                res
);

	logic                        pilot_fault;
	logic [evcp_pkg::AmpsW-1:0]  min_amps;
	logic [evcp_pkg::StateW-1:0] nxt;
	logic [evcp_pkg::AmpsW-1:0]  cur_amps;
	logic                        cmd;
	logic [evcp_pkg::ErrW-1:0]   report;
	logic                        clr;

	assign pilot_fault = item.pilot_state > evcp_pkg::PL_D;
	assign min_amps    = (item.cable_rating_amps < charger_limit_amps) ?
	                     item.cable_rating_amps : charger_limit_amps;

	always_comb begin
		nxt      = cur_state;
		cur_amps = cur_current;
		cmd      = cur_contactor;
		report   = evcp_pkg::ERR_NONE;
		clr      = 1'b0;

		if (cur_state != evcp_pkg::ST_FAULT && (item.error_pending || pilot_fault)) begin
			// forced fault: current and contactor hold for this tick
			nxt = evcp_pkg::ST_FAULT;
		end else begin
			case (cur_state)
				evcp_pkg::ST_IDLE: begin
					if (item.pilot_state inside {evcp_pkg::PL_B, evcp_pkg::PL_C,
					                              evcp_pkg::PL_D}) begin
						if (!item.cable_valid) begin
							nxt = evcp_pkg::ST_FAULT;
						end else begin
							cur_amps = min_amps;
							if (item.pilot_state == evcp_pkg::PL_B) begin
								nxt = evcp_pkg::ST_CONNECTED;
							end else if (item.pilot_state == evcp_pkg::PL_C) begin
								nxt = evcp_pkg::ST_CHARGE_REQ;
							end else begin
								report = evcp_pkg::ERR_INVALID_STATE;
								nxt    = evcp_pkg::ST_FAULT;
							end
						end
					end
					cmd = 1'b0;
				end
				evcp_pkg::ST_CONNECTED: begin
					if (item.pilot_state == evcp_pkg::PL_C) begin
						nxt = evcp_pkg::ST_CHARGE_REQ;
					end else if (item.pilot_state == evcp_pkg::PL_A) begin
						nxt      = evcp_pkg::ST_IDLE;
						cur_amps = '0;
					end
					cmd = 1'b0;
				end
				evcp_pkg::ST_CHARGE_REQ: begin
					if (item.contactor_feedback_closed) begin
						cmd = 1'b1;
						nxt = evcp_pkg::ST_CHARGING;
					end else begin
						report = evcp_pkg::ERR_CONTACTOR;
						cmd    = 1'b0;
						nxt    = evcp_pkg::ST_FAULT;
					end
				end
				evcp_pkg::ST_CHARGING: begin
					if (item.pilot_state inside {evcp_pkg::PL_A, evcp_pkg::PL_B}) begin
						cmd = 1'b0;
						if (item.contactor_feedback_closed) begin
							// welded or stuck contactor
							report = evcp_pkg::ERR_CONTACTOR;
							nxt    = evcp_pkg::ST_FAULT;
						end else if (item.pilot_state == evcp_pkg::PL_B) begin
							nxt = evcp_pkg::ST_CONNECTED;
						end else begin
							nxt      = evcp_pkg::ST_IDLE;
							cur_amps = '0;
						end
					end
				end
				evcp_pkg::ST_VENTILATION: begin
					cmd = 1'b0;
					nxt = evcp_pkg::ST_FAULT;
				end
				evcp_pkg::ST_FAULT: begin
					cmd      = 1'b0;
					cur_amps = '0;
					if (item.pilot_state == evcp_pkg::PL_A &&
					    !item.contactor_feedback_closed) begin
						clr = 1'b1;
						nxt = evcp_pkg::ST_IDLE;
					end
				end
				default: begin
					report   = evcp_pkg::ERR_INVALID_STATE;
					cmd      = 1'b0;
					cur_amps = '0;
					nxt      = evcp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign res.state              = nxt;
	assign res.pilot_current_amps = cur_amps;
	assign res.contactor_on       = cmd;
	assign res.error_report       = report;
	assign res.error_clear        = clr;
	assign res.state_changed      = (nxt != cur_state);

endmodule

`default_nettype wire

// File: design/ev_charge_pilot_controller.sv
`default_nettype none

// Control pilot state machine for an EV charger. One input beat is one polling tick (pilot
// level, cable rating, contactor feedback, pending error) and yields exactly one output beat
// with the new control state, advertised current, contactor command and error flags. Beats
// pass through an input register and then an output register, where the result is presented;
// a new beat is taken every cycle when the output is not stalled. The only loop is the state,
// current and contactor registers, updated in the same cycle as the decision.
// charger_limit_amps resets to 32 A and is written with cfg_write_en/cfg_write_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
module ev_charge_pilot_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        cfg_write_en,
	input  wire logic [evcp_pkg::AmpsW-1:0]  cfg_write_data,

	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [evcp_pkg::PilotW-1:0] pilot_state,
	input  wire logic [evcp_pkg::AmpsW-1:0]  cable_rating_amps,
	input  wire logic                        cable_valid,
	input  wire logic                        contactor_feedback_closed,
	input  wire logic                        error_pending,

	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [evcp_pkg::StateW-1:0]      control_state,
	output logic [evcp_pkg::AmpsW-1:0]       pilot_current_amps,
	output logic                             contactor_on,
	output logic [evcp_pkg::ErrW-1:0]        error_report,
	output logic                             error_clear,
	output logic                             state_changed
);

	// configuration
	logic [evcp_pkg::AmpsW-1:0]  limit_q;

	// controller state
	logic [evcp_pkg::StateW-1:0] state_q;
	logic [evcp_pkg::AmpsW-1:0]  current_q;
	logic                        contactor_q;

	// pipeline
	logic                        valid_s1;
	evcp_pkg::item_t             item_s1;
	logic                        valid_s2;
	evcp_pkg::result_t           res_s2;

	evcp_pkg::result_t           step_res;
	logic                        adv_s1;
	logic                        take_in;

	// stage 2 frees when empty or its beat leaves this cycle
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= evcp_pkg::LimitReset;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.pilot_state               <= pilot_state;
			item_s1.cable_rating_amps         <= cable_rating_amps;
			item_s1.cable_valid               <= cable_valid;
			item_s1.contactor_feedback_closed <= contactor_feedback_closed;
			item_s1.error_pending             <= error_pending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	evcp_step u_step (
		.cur_state          (state_q),
		.cur_current        (current_q),
		.cur_contactor      (contactor_q),
		.charger_limit_amps (limit_q),
		.item               (item_s1),
		.res                (step_res)
	);

	// state advances exactly when a decision moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= evcp_pkg::ST_IDLE;
			current_q   <= '0;
			contactor_q <= 1'b0;
		end else if (adv_s1) begin
			state_q     <= step_res.state;
			current_q   <= step_res.pilot_current_amps;
			contactor_q <= step_res.contactor_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid          = valid_s2;
	assign control_state      = res_s2.state;
	assign pilot_current_amps = res_s2.pilot_current_amps;
	assign contactor_on       = res_s2.contactor_on;
	assign error_report       = res_s2.error_report;
	assign error_clear        = res_s2.error_clear;
	assign state_changed      = res_s2.state_changed;

endmodule

`default_nettype wire

// File: tb/sv/tb_ev_charge_pilot_controller.sv
`default_nettype none

// Tracks the pilot state machine and holds the decisions still owed by the block.
class pilot_decision_board;
	evcp_pkg::state_t                ctl_state;
	logic [evcp_pkg::AmpsW-1:0]      adv_current;
	logic                            contactor_cmd;
	logic [evcp_pkg::AmpsW-1:0]      limit_amps;
	evcp_pkg::result_t               owed_decisions[$];
	int unsigned                     errors;

	function new();
		ctl_state     = evcp_pkg::ST_IDLE;
		adv_current   = '0;
		contactor_cmd = 1'b0;
		limit_amps    = evcp_pkg::LimitReset;
		errors        = 0;
	endfunction

	function int unsigned pending();
		return owed_decisions.size();
	endfunction

	// Step the machine for one accepted tick and queue the decision it owes.
	function void log_tick(evcp_pkg::item_t t);
		evcp_pkg::result_t          r;
		evcp_pkg::state_t           prior;
		evcp_pkg::state_t           nxt;
		logic [evcp_pkg::ErrW-1:0]  rep;
		logic                       clr;
		prior = ctl_state;
		nxt   = prior;
		rep   = evcp_pkg::ERR_NONE;
		clr   = 1'b0;
		if (prior != evcp_pkg::ST_FAULT &&
		    (t.error_pending || t.pilot_state > evcp_pkg::PL_D)) begin
			// forced fault: current and contactor held this tick
			nxt = evcp_pkg::ST_FAULT;
		end else begin
			case (prior)
				evcp_pkg::ST_IDLE: begin
					if (t.pilot_state != evcp_pkg::PL_A) begin
						if (!t.cable_valid) begin
							nxt = evcp_pkg::ST_FAULT;
						end else begin
							adv_current = (t.cable_rating_amps < limit_amps) ?
								t.cable_rating_amps : limit_amps;
							if (t.pilot_state == evcp_pkg::PL_B) begin
								nxt = evcp_pkg::ST_CONNECTED;
							end else if (t.pilot_state == evcp_pkg::PL_C) begin
								nxt = evcp_pkg::ST_CHARGE_REQ;
							end else begin
								rep = evcp_pkg::ERR_INVALID_STATE;
								nxt = evcp_pkg::ST_FAULT;
							end
						end
					end
					contactor_cmd = 1'b0;
				end
				evcp_pkg::ST_CONNECTED: begin
					if (t.pilot_state == evcp_pkg::PL_C) begin
						nxt = evcp_pkg::ST_CHARGE_REQ;
					end else if (t.pilot_state == evcp_pkg::PL_A) begin
						nxt         = evcp_pkg::ST_IDLE;
						adv_current = '0;
					end
					contactor_cmd = 1'b0;
				end
				evcp_pkg::ST_CHARGE_REQ: begin
					if (t.contactor_feedback_closed) begin
						contactor_cmd = 1'b1;
						nxt           = evcp_pkg::ST_CHARGING;
					end else begin
						rep           = evcp_pkg::ERR_CONTACTOR;
						contactor_cmd = 1'b0;
						nxt           = evcp_pkg::ST_FAULT;
					end
				end
				evcp_pkg::ST_CHARGING: begin
					if (t.pilot_state == evcp_pkg::PL_B || t.pilot_state == evcp_pkg::PL_A) begin
						contactor_cmd = 1'b0;
						if (t.contactor_feedback_closed) begin
							rep = evcp_pkg::ERR_CONTACTOR;
							nxt = evcp_pkg::ST_FAULT;
						end else if (t.pilot_state == evcp_pkg::PL_B) begin
							nxt = evcp_pkg::ST_CONNECTED;
						end else begin
							nxt         = evcp_pkg::ST_IDLE;
							adv_current = '0;
						end
					end
				end
				evcp_pkg::ST_VENTILATION: begin
					contactor_cmd = 1'b0;
					nxt           = evcp_pkg::ST_FAULT;
				end
				evcp_pkg::ST_FAULT: begin
					contactor_cmd = 1'b0;
					adv_current   = '0;
					if (t.pilot_state == evcp_pkg::PL_A && !t.contactor_feedback_closed) begin
						clr = 1'b1;
						nxt = evcp_pkg::ST_IDLE;
					end
				end
				default: begin
					rep           = evcp_pkg::ERR_INVALID_STATE;
					contactor_cmd = 1'b0;
					adv_current   = '0;
					nxt           = evcp_pkg::ST_IDLE;
				end
			endcase
		end
		ctl_state         = nxt;
		r.state           = nxt;
		r.pilot_current_amps = adv_current;
		r.contactor_on    = contactor_cmd;
		r.error_report    = rep;
		r.error_clear     = clr;
		r.state_changed   = (nxt != prior);
		owed_decisions.push_back(r);
	endfunction

	function void match(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_decision(evcp_pkg::result_t got);
		evcp_pkg::result_t want;
		if (owed_decisions.size() == 0) begin
			$error("decision beat with nothing owed");
			errors++;
			return;
		end
		want = owed_decisions.pop_front();
		match("control_state", want.state, got.state);
		match("pilot_current_amps", want.pilot_current_amps, got.pilot_current_amps);
		match("contactor_on", want.contactor_on, got.contactor_on);
		match("error_report", want.error_report, got.error_report);
		match("error_clear", want.error_clear, got.error_clear);
		match("state_changed", want.state_changed, got.state_changed);
	endfunction
endclass

module tb_ev_charge_pilot_controller;

	localparam int unsigned TIMEOUT_CYCLES = 200_000;
	localparam int unsigned PHASE_TICKS    = 300;
	localparam int unsigned PHASES         = 6;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// config port
	logic                        cfg_write_en   = 1'b0;
	logic [evcp_pkg::AmpsW-1:0]  cfg_write_data = '0;

	// tick input channel
	logic                        in_valid                  = 1'b0;
	logic                        in_stall;
	logic [evcp_pkg::PilotW-1:0] pilot_state               = evcp_pkg::PL_A;
	logic [evcp_pkg::AmpsW-1:0]  cable_rating_amps         = '0;
	logic                        cable_valid               = 1'b0;
	logic                        contactor_feedback_closed = 1'b0;
	logic                        error_pending             = 1'b0;

	// decision output channel
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [evcp_pkg::StateW-1:0] control_state;
	logic [evcp_pkg::AmpsW-1:0]  pilot_current_amps;
	logic                        contactor_on;
	logic [evcp_pkg::ErrW-1:0]   error_report;
	logic                        error_clear;
	logic                        state_changed;

	// set during one phase to give a long run with no gaps on either side
	bit calm = 1'b0;

	pilot_decision_board board = new();

	ev_charge_pilot_controller dut (
		.clk                       (clk),
		.arst_n                    (arst_n),
		.cfg_write_en              (cfg_write_en),
		.cfg_write_data            (cfg_write_data),
		.in_valid                  (in_valid),
		.in_stall                  (in_stall),
		.pilot_state               (pilot_state),
		.cable_rating_amps         (cable_rating_amps),
		.cable_valid               (cable_valid),
		.contactor_feedback_closed (contactor_feedback_closed),
		.error_pending             (error_pending),
		.out_valid                 (out_valid),
		.out_stall                 (out_stall),
		.control_state             (control_state),
		.pilot_current_amps        (pilot_current_amps),
		.contactor_on              (contactor_on),
		.error_report              (error_report),
		.error_clear               (error_clear),
		.state_changed             (state_changed)
	);

	// 8-unit period
	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// Receiver: random back-pressure at a 7 percent chance, none while calm.
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 7);
	end

	// Output monitor. Reads in the active region after the edge see pre-edge
	// values, since every driver here and in the block updates by NBA.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_decision({control_state, pilot_current_amps, contactor_on,
				error_report, error_clear, state_changed});
		end
	end

	function automatic evcp_pkg::item_t mk_tick(logic [evcp_pkg::PilotW-1:0] p,
			logic [evcp_pkg::AmpsW-1:0] amps, logic ok, logic fb, logic err);
		evcp_pkg::item_t t;
		t.pilot_state               = p;
		t.cable_rating_amps         = amps;
		t.cable_valid               = ok;
		t.contactor_feedback_closed = fb;
		t.error_pending             = err;
		return t;
	endfunction

	// Present one tick beat and hold it until taken. Valid only drops for a
	// random gap; back-to-back beats keep it high with no glitch in the step.
	task automatic send_tick(input evcp_pkg::item_t t);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid                  <= 1'b1;
		pilot_state               <= t.pilot_state;
		cable_rating_amps         <= t.cable_rating_amps;
		cable_valid               <= t.cable_valid;
		contactor_feedback_closed <= t.contactor_feedback_closed;
		error_pending             <= t.error_pending;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.log_tick(t);
	endtask

	// Stop sending and wait for every owed decision, then let the pipe settle.
	task automatic drain_decisions();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic set_limit(input logic [evcp_pkg::AmpsW-1:0] v);
		cfg_write_data <= v;
		cfg_write_en   <= 1'b1;
		@(posedge clk);
		cfg_write_en     <= 1'b0;
		board.limit_amps = v;
	endtask

	// Random ticks that mostly follow a plausible charging session: the
	// feedback usually tracks what the contactor should be doing, so that
	// charging is reached and left cleanly, with the odd contactor fault,
	// pilot fault, stored error or unknown cable thrown in.
	task automatic run_session(input int unsigned n);
		evcp_pkg::item_t t;
		int unsigned     roll;
		for (int unsigned i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 27)
				t.pilot_state = evcp_pkg::PL_A;
			else if (roll < 54)
				t.pilot_state = evcp_pkg::PL_B;
			else if (roll < 81)
				t.pilot_state = evcp_pkg::PL_C;
			else if (roll < 93)
				t.pilot_state = evcp_pkg::PL_D;
			else
				t.pilot_state = 3'($urandom_range(7, 4));
			t.cable_rating_amps = 6'($urandom_range(63));
			t.cable_valid       = ($urandom_range(99) < 95);
			t.error_pending     = ($urandom_range(99) < 3);
			case (board.ctl_state)
				evcp_pkg::ST_CHARGE_REQ:
					t.contactor_feedback_closed = ($urandom_range(99) < 85);
				evcp_pkg::ST_CHARGING: begin
					if (t.pilot_state == evcp_pkg::PL_A || t.pilot_state == evcp_pkg::PL_B)
						t.contactor_feedback_closed = ($urandom_range(99) < 15);
					else
						t.contactor_feedback_closed = ($urandom_range(99) < 90);
				end
				default: t.contactor_feedback_closed = ($urandom_range(99) < 10);
			endcase
			send_tick(t);
			// sender holds off now and then until the block has caught up
			if (i % 100 == 99)
				drain_decisions();
		end
	endtask

	initial begin
		logic [evcp_pkg::AmpsW-1:0] lim;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk at the reset limit of 32 A
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd63, 1'b1, 1'b0, 1'b0)); // idle holds
		send_tick(mk_tick(evcp_pkg::PL_B, 6'd63, 1'b1, 1'b0, 1'b0)); // connect, clipped
		send_tick(mk_tick(evcp_pkg::PL_D, 6'd0,  1'b1, 1'b0, 1'b0)); // D ignored, connected
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd0,  1'b1, 1'b0, 1'b0)); // charge request
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd0,  1'b1, 1'b1, 1'b0)); // contactor closes
		send_tick(mk_tick(evcp_pkg::PL_D, 6'd0,  1'b1, 1'b1, 1'b0)); // D ignored, charging
		send_tick(mk_tick(evcp_pkg::PL_B, 6'd0,  1'b1, 1'b0, 1'b0)); // back to connected
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0)); // unplug to idle
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd5,  1'b1, 1'b0, 1'b0)); // straight to request
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd5,  1'b1, 1'b0, 1'b0)); // feedback stuck open
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b1, 1'b0)); // no recovery, closed
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0)); // recovery with clear
		send_tick(mk_tick(evcp_pkg::PL_D, 6'd10, 1'b1, 1'b0, 1'b0)); // D at connection
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b0, 1'b0, 1'b1)); // stored error no block
		send_tick(mk_tick(evcp_pkg::PL_B, 6'd0,  1'b0, 1'b0, 1'b0)); // unknown cable
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(3'd6,           6'd0,  1'b1, 1'b0, 1'b0)); // out-of-range pilot
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_B, 6'd0,  1'b1, 1'b0, 1'b0)); // 0 A cable
		send_tick(mk_tick(3'd7,           6'd0,  1'b1, 1'b0, 1'b0)); // pilot fault, connected
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd31, 1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd0,  1'b1, 1'b1, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_B, 6'd0,  1'b1, 1'b1, 1'b1)); // forced fault, held
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd20, 1'b1, 1'b0, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_C, 6'd0,  1'b1, 1'b1, 1'b0));
		send_tick(mk_tick(evcp_pkg::PL_A, 6'd0,  1'b1, 1'b1, 1'b0)); // unplug, welded
		drain_decisions();

		// random sessions across several limits, extremes first
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: lim = '0;
				1: lim = 6'd63;
				2: lim = 6'd1;
				3: lim = evcp_pkg::LimitReset;
				default: lim = 6'($urandom_range(63));
			endcase
			set_limit(lim);
			calm = (ph == 3);
			run_session(PHASE_TICKS);
			drain_decisions();
		end
		calm = 1'b0;

		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#(TIMEOUT_CYCLES * 8);
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
design/evcp_pkg.sv
design/evcp_step.sv
design/ev_charge_pilot_controller.sv
tb/sv/tb_ev_charge_pilot_controller.sv
